>>> rtl/dac_waveform_sample_generator_defines.svh
// Assertion macros used by the checker file of the waveform generator.
// No dependencies; taken in by `include.
`ifndef DAC_WAVEFORM_SAMPLE_GENERATOR_DEFINES_SVH
`define DAC_WAVEFORM_SAMPLE_GENERATOR_DEFINES_SVH

// Checked only outside reset.
`define DWSG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define DWSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dwsg_pkg.sv
// Types, constants and the sine table builder of the waveform generator.
// No dependencies.
package dwsg_pkg;

  localparam int IDX_W      = 12;
  localparam int SMP_W      = 12;
  localparam int MODE_W     = 2;
  localparam int PPP_W      = 13;
  localparam int RATIO_W    = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_POINTS       = 4096;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_W          = $clog2(SINE_TABLE_DEPTH);
  localparam int ROM_DEPTH        = SINE_TABLE_DEPTH / 4;
  localparam int ROM_AW           = $clog2(ROM_DEPTH);
  localparam int MAG_W            = 15;

  localparam int DAC_FULL  = 4095;
  localparam int RATIO_ONE = 65536;

  localparam int HALF_W = PPP_W - 1;          // h = n/2
  localparam int D_W    = PPP_W - 2;          // d = h-1, also the ramp position
  localparam int AMP_W  = 29;                 // 4095 * ratio
  localparam int PROD_W = AMP_W + D_W;
  localparam int DVD_W  = 24;
  localparam int DVS_W  = PPP_W;
  localparam int QUO_W  = 12;
  localparam int SPROD_W = AMP_W + 1 + MAG_W + 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Taylor term divisors (2k)(2k+1) for k = 1..6
  localparam longint unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

  typedef enum logic [MODE_W-1:0] {
    MODE_SINE     = 2'd0,
    MODE_SQUARE   = 2'd1,
    MODE_TRIANGLE = 2'd2,
    MODE_SINE_ALT = 2'd3
  } wave_mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 2'd2;

  typedef struct packed {
    wave_mode_t              mode;
    logic [PPP_W-1:0]        n;
    logic [HALF_W-1:0]       h;
    logic [D_W-1:0]          d;
    logic [AMP_W-1:0]        amp;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic err;
    logic pend;
    logic tri_zero;
    logic sq_high;
  } ctl_t;

  typedef logic [MAG_W-1:0] sin_rom_t [ROM_DEPTH];

  // |sin(pi/2 * q/ROM_DEPTH)| in Q15, Taylor series to x^13 in Q2.30
  function automatic logic [MAG_W-1:0] sin_mag(input int unsigned q);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    int unsigned     k;
    x    = (longint'(q) * HALF_PI_Q30) >> ROM_AW;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 6; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[k-1];
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return MAG_W'(sum);
  endfunction

  function automatic sin_rom_t sin_rom_build();
    sin_rom_t rom;
    for (int q = 0; q < ROM_DEPTH; q++) rom[q] = sin_mag(q);
    return rom;
  endfunction

  localparam logic [MAG_W-1:0] SIN_PEAK = sin_mag(ROM_DEPTH);

endpackage

>>> rtl/dwsg_if.sv
// Request channels of the waveform generator: index in, sample out.
// Depends on dwsg_pkg.
interface dwsg_in_if;
  import dwsg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;
  modport source (output valid, sample_index, input ready);
  modport sink   (input valid, sample_index, output ready);
endinterface

interface dwsg_out_if;
  import dwsg_pkg::*;
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample;
  logic             period_end;
  logic             index_error;
  modport source (output valid, sample, period_end, index_error, input ready);
  modport sink   (input valid, sample, period_end, index_error, output ready);
endinterface

>>> rtl/dac_waveform_sample_generator.sv
// DAC waveform sample generator: sine, square or triangle code per index.
// Usage:
//   sample_in carries a sample_index request (valid/ready). sample_out returns
//   one result per request in order: a 12-bit sample, period_end on the last
//   point of the period and index_error for an index at or past the period.
//   The cfg port (cfg_write, cfg_index, cfg_data) sets wave_mode (index 0),
//   points_per_period (1) and amplitude_ratio (2); write it only while idle.
//   Throughput is one request per clock while sample_out is not stalled. The
//   pipe has 18 register stages: 3 front stages, 12 divider stages (one
//   quotient bit each, for the sine phase and the triangle scaling) and 3
//   back stages.
//   The whole pipe moves as one: while sample_out.valid is high and
//   sample_out.ready low, sample_in.ready drops and every stage holds.
//   Reset is synchronous: the pipe empties and the registers return to sine,
//   256 points per period and full-scale ratio.
// Depends on dwsg_pkg, dwsg_if, dwsg_front, dwsg_div, dwsg_back.
module dac_waveform_sample_generator (
  input  logic                            clk,
  input  logic                            rst,
  dwsg_in_if.sink                         sample_in,
  dwsg_out_if.source                      sample_out,
  input  logic                            cfg_write,
  input  logic [dwsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dwsg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dwsg_pkg::*;

  wave_mode_t         wave_mode;
  logic [PPP_W-1:0]   points_per_period;
  logic [RATIO_W-1:0] amplitude_ratio;
  logic [RATIO_W-1:0] r_eff;
  logic [AMP_W-1:0]   amp;
  cfg_t               cfg;
  logic               adv;
  ctl_t               ctl_f, ctl_d;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [QUO_W-1:0]   quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode         <= MODE_SINE;
      points_per_period <= PPP_W'(256);
      amplitude_ratio   <= RATIO_W'(RATIO_ONE);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WAVE_MODE: wave_mode         <= wave_mode_t'(cfg_data[MODE_W-1:0]);
        REG_POINTS:    points_per_period <= cfg_data[PPP_W-1:0];
        REG_RATIO:     amplitude_ratio   <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign r_eff = (amplitude_ratio > RATIO_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE)
                                                         : amplitude_ratio;

  // registered; first used by the amplitude product behind the m1 register
  always_ff @(posedge clk) begin
    amp <= (AMP_W'(r_eff) << 12) - AMP_W'(r_eff);
  end

  always_comb begin
    cfg.mode = wave_mode;
    cfg.n    = (points_per_period > PPP_W'(MAX_POINTS)) ? PPP_W'(MAX_POINTS)
                                                         : points_per_period;
    cfg.h    = cfg.n[PPP_W-1:1];
    cfg.d    = (cfg.h > HALF_W'(1)) ? D_W'(cfg.h - HALF_W'(1)) : D_W'(1);
    cfg.amp  = amp;
  end

  assign adv             = !sample_out.valid || sample_out.ready;
  assign sample_in.ready = adv;

  dwsg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (sample_in.valid),
    .sample_index (sample_in.sample_index),
    .cfg          (cfg),
    .ctl_out      (ctl_f),
    .dvd_out      (dvd),
    .dvs_out      (dvs)
  );

  dwsg_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (ctl_f),
    .dvd     (dvd),
    .dvs     (dvs),
    .ctl_out (ctl_d),
    .quo     (quo)
  );

  dwsg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cfg         (cfg),
    .ctl_in      (ctl_d),
    .quo         (quo),
    .out_valid   (sample_out.valid),
    .sample      (sample_out.sample),
    .period_end  (sample_out.period_end),
    .index_error (sample_out.index_error)
  );

endmodule

>>> rtl/dwsg_front.sv
// Front stages: index checks, ramp position, amplitude product, divider operands.
// Depends on dwsg_pkg.
module dwsg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [dwsg_pkg::IDX_W-1:0] sample_index,
  input  dwsg_pkg::cfg_t             cfg,
  output dwsg_pkg::ctl_t             ctl_out,
  output logic [dwsg_pkg::DVD_W-1:0] dvd_out,
  output logic [dwsg_pkg::DVS_W-1:0] dvs_out
);
  import dwsg_pkg::*;

  ctl_t              ctl0, ctl1, ctl2, ctl3;
  logic [IDX_W-1:0]  j0;
  logic [D_W-1:0]    m0, m1;
  logic [IDX_W-1:0]  i1, i2;
  logic [PROD_W-1:0] prod2;
  logic [PROD_W:0]   tri_num;
  logic [DVD_W-1:0]  dvd3;
  logic [DVS_W-1:0]  dvs3;

  always_comb begin
    ctl0.valid    = in_valid;
    ctl0.err      = {1'b0, sample_index} >= cfg.n;
    ctl0.pend     = {1'b0, sample_index} == (cfg.n - PPP_W'(1));
    ctl0.sq_high  = sample_index < cfg.h;
    j0            = sample_index - cfg.h;
    ctl0.tri_zero = !ctl0.sq_high && (j0 > IDX_W'(cfg.d));
    m0 = ctl0.sq_high ? D_W'(sample_index) : (cfg.d - D_W'(j0));
  end

  // triangle: 2*amp*m + 65536*d, then drop the 2^17 scale before dividing by d
  assign tri_num = {prod2, 1'b0} + ((PROD_W+1)'(cfg.d) << 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
    end else if (adv) begin
      ctl1 <= ctl0;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i1    <= sample_index;
      m1    <= m0;
      i2    <= i1;
      prod2 <= PROD_W'(cfg.amp * m1);
      if (cfg.mode == MODE_TRIANGLE) begin
        dvd3 <= tri_num[PROD_W -: DVD_W];
        dvs3 <= DVS_W'(cfg.d);
      end else begin
        dvd3 <= DVD_W'(i2) << PHASE_W;
        dvs3 <= cfg.n;
      end
    end
  end

  assign ctl_out = ctl3;
  assign dvd_out = dvd3;
  assign dvs_out = dvs3;

endmodule

>>> rtl/dwsg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dwsg_pkg.
module dwsg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  dwsg_pkg::ctl_t             ctl_in,
  input  logic [dwsg_pkg::DVD_W-1:0] dvd,
  input  logic [dwsg_pkg::DVS_W-1:0] dvs,
  output dwsg_pkg::ctl_t             ctl_out,
  output logic [dwsg_pkg::QUO_W-1:0] quo
);
  import dwsg_pkg::*;

  ctl_t             ctl_r [QUO_W];
  logic [DVD_W-1:0] rem_r [QUO_W];
  logic [DVS_W-1:0] dvs_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int BIT = QUO_W - 1 - s;
    ctl_t             c_in;
    logic [DVD_W-1:0] r_in;
    logic [DVS_W-1:0] d_in;
    logic [QUO_W-1:0] q_in;
    logic [DVD_W-1:0] trial;

    if (s == 0) begin : g_first
      assign c_in = ctl_in;
      assign r_in = dvd;
      assign d_in = dvs;
      assign q_in = '0;
    end else begin : g_next
      assign c_in = ctl_r[s-1];
      assign r_in = rem_r[s-1];
      assign d_in = dvs_r[s-1];
      assign q_in = quo_r[s-1];
    end

    assign trial = DVD_W'(d_in) << BIT;

    always_ff @(posedge clk) begin
      if (rst) ctl_r[s] <= '0;
      else if (adv) ctl_r[s] <= c_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvs_r[s] <= d_in;
        if (r_in >= trial) begin
          rem_r[s] <= r_in - trial;
          quo_r[s] <= q_in | (QUO_W'(1) << BIT);
        end else begin
          rem_r[s] <= r_in;
          quo_r[s] <= q_in;
        end
      end
    end
  end

  assign ctl_out = ctl_r[QUO_W-1];
  assign quo     = quo_r[QUO_W-1];

endmodule

>>> rtl/dwsg_back.sv
// Back stages: sine fold and table, amplitude multiply, rounding, square and triangle select, output register.
// Depends on dwsg_pkg.
module dwsg_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  dwsg_pkg::cfg_t             cfg,
  input  dwsg_pkg::ctl_t             ctl_in,
  input  logic [dwsg_pkg::QUO_W-1:0] quo,
  output logic                       out_valid,
  output logic [dwsg_pkg::SMP_W-1:0] sample,
  output logic                       period_end,
  output logic                       index_error
);
  import dwsg_pkg::*;

  localparam sin_rom_t SIN_ROM = sin_rom_build();
  localparam int FOLD_W = PHASE_W - 1;

  ctl_t                      ctl1, ctl2;
  logic [FOLD_W-1:0]         fold;
  logic [FOLD_W-1:0]         qf;
  logic [MAG_W-1:0]          mag;
  logic signed [MAG_W:0]     s1;
  logic [SMP_W-1:0]          alt1, alt2;
  logic [AMP_W:0]            sq_hi_sum, sq_lo_sum;
  logic [SMP_W-1:0]          sq_val;
  logic signed [SPROD_W-1:0] sprod2;
  logic signed [SPROD_W:0]   v;
  logic [SPROD_W-32:0]       v_hi;
  logic [SMP_W-1:0]          sine_val;
  logic                      is_sine;

  // second half of the period goes negative; fold the quarter above the peak
  always_comb begin
    fold = quo[FOLD_W-1:0];
    qf   = (fold > FOLD_W'(ROM_DEPTH)) ? (FOLD_W'(2 * ROM_DEPTH) - fold) : fold;
    mag  = qf[ROM_AW] ? SIN_PEAK : SIN_ROM[qf[ROM_AW-1:0]];
  end

  assign sq_hi_sum = (AMP_W+1)'(1 << 28) + (AMP_W+1)'(cfg.amp);
  assign sq_lo_sum = (AMP_W+1)'(1 << 28) - (AMP_W+1)'(cfg.amp);
  assign sq_val    = ctl_in.sq_high ? SMP_W'(sq_hi_sum >> 17) : SMP_W'(sq_lo_sum >> 17);
  assign is_sine   = (cfg.mode != MODE_SQUARE) && (cfg.mode != MODE_TRIANGLE);

  // 4095*2^31 + 2^31 = 2^43
  assign v    = (SPROD_W+1)'(sprod2) + (SPROD_W+1)'(64'd1 << 43);
  assign v_hi = v[SPROD_W:32];
  assign sine_val = (v_hi > (SPROD_W-31)'(DAC_FULL)) ? SMP_W'(DAC_FULL) : SMP_W'(v_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1      <= '0;
      ctl2      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      ctl1      <= ctl_in;
      ctl2      <= ctl1;
      out_valid <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= quo[FOLD_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      case (cfg.mode)
        MODE_SQUARE:   alt1 <= sq_val;
        MODE_TRIANGLE: alt1 <= ctl_in.tri_zero ? '0 : quo;
        default:       alt1 <= '0;
      endcase
      sprod2 <= SPROD_W'($signed({1'b0, cfg.amp}) * s1);
      alt2   <= alt1;
      if (ctl2.err)     sample <= '0;
      else if (is_sine) sample <= sine_val;
      else              sample <= alt2;
      period_end  <= ctl2.pend && !ctl2.err;
      index_error <= ctl2.err;
    end
  end

endmodule

>>> rtl/dwsg_checker.sv
// Port-level checks of the waveform generator, bound to the top level.
// Depends on dwsg_pkg and dac_waveform_sample_generator_defines.svh.
`include "dac_waveform_sample_generator_defines.svh"

module dwsg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dwsg_pkg::SMP_W-1:0] sample,
  input logic                       period_end,
  input logic                       index_error
);
  import dwsg_pkg::*;

  `DWSG_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(sample), "stalled sample changed")
  `DWSG_ASSERT(a_err_zero, clk, rst, out_valid && index_error |-> sample == '0 && !period_end, "error result not zero")
  `DWSG_ASSERT(a_ready, clk, rst, !in_ready |-> out_valid && !out_ready, "input blocked without output stall")
  `DWSG_ASSERT_ALWAYS(a_reset, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind dac_waveform_sample_generator dwsg_checker u_dwsg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (sample_in.ready),
  .out_valid   (sample_out.valid),
  .out_ready   (sample_out.ready),
  .sample      (sample_out.sample),
  .period_end  (sample_out.period_end),
  .index_error (sample_out.index_error)
);

>>> tb/dac_waveform_sample_generator_test.sv
// Self-checking testbench for dac_waveform_sample_generator: directed and random
// requests against an in-bench sample predictor. Depends on dwsg_pkg, dwsg_if.
`timescale 1ns / 1ps
module dac_waveform_sample_generator_test;
  import dwsg_pkg::*;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             period_end;
    logic             index_error;
  } dac_code_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dwsg_in_if  sample_in ();
  dwsg_out_if sample_out ();

  dac_waveform_sample_generator dut (
    .clk(clk), .rst(rst), .sample_in(sample_in), .sample_out(sample_out),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the configuration
  wave_mode_t        shape;
  logic [PPP_W-1:0]  period_len;
  logic [RATIO_W-1:0] ratio_q16;

  dac_code_t pending_codes[$];
  int        errors;
  bit        gaps_on;
  int        stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("dac_waveform_sample_generator: mismatch");
    $finish;
  end

  // Q15 magnitude of sin(pi/2 * u/1024), Taylor series in Q2.30
  function automatic longint quarter_sine_q15(longint unsigned u);
    longint unsigned ang;
    longint unsigned pw;
    longint          acc;
    ang = (u * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    pw  = ang;
    acc = longint'(ang);
    for (int j = 1; j <= 6; j++) begin
      pw = (pw * ang) >> 30;
      pw = (pw * ang) >> 30;
      pw = pw / longint'((2 * j) * (2 * j + 1));
      if (j % 2 == 1) acc = acc - longint'(pw);
      else            acc = acc + longint'(pw);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) acc = 32767;
    return acc;
  endfunction

  function automatic dac_code_t predict_code(logic [IDX_W-1:0] idx);
    dac_code_t       c;
    longint unsigned n, r, i, h, d, m, u, v;
    longint          s, sv;
    bit              neg;
    n = period_len;
    r = (ratio_q16 > RATIO_ONE) ? RATIO_ONE : ratio_q16;
    i = idx;
    if (n > MAX_POINTS) n = MAX_POINTS;
    c = '0;
    if (i >= n) begin
      c.index_error = 1'b1;
      return c;
    end
    c.period_end = (i == n - 1);
    case (shape)
      MODE_SQUARE: begin
        if (i < n / 2) v = (64'd4095 * 65536 + 64'd4095 * r + 65536) >> 17;
        else           v = (64'd4095 * 65536 - 64'd4095 * r + 65536) >> 17;
      end
      MODE_TRIANGLE: begin
        h = n / 2;
        d = (h > 1) ? h - 1 : 1;
        if (i < h) m = i;
        else m = ((i - h) > d) ? 64'hFFFF_FFFF : d - (i - h);
        // falling past zero on the last point of an odd period
        if (m == 64'hFFFF_FFFF) v = 0;
        else v = (64'd2 * 4095 * r * m + 65536 * d) / (64'd131072 * d);
      end
      default: begin
        u = 4 * ((i * SINE_TABLE_DEPTH) / n);
        neg = 1'b0;
        if (u >= 2 * SINE_TABLE_DEPTH) begin
          neg = 1'b1;
          u = u - 2 * SINE_TABLE_DEPTH;
        end
        if (u > SINE_TABLE_DEPTH) u = 2 * SINE_TABLE_DEPTH - u;
        s = quarter_sine_q15(u);
        if (neg) s = -s;
        sv = 64'sd4095 * 64'sd2147483648 + 64'sd4095 * longint'(r) * s + 64'sd2147483648;
        v = (sv < 0) ? 0 : longint'(sv >>> 32);
      end
    endcase
    c.sample = (v > DAC_FULL) ? SMP_W'(DAC_FULL) : SMP_W'(v);
    return c;
  endfunction

  // Result channel: random stall bursts, none while gaps are off
  always @(posedge clk) begin
    if (rst || !gaps_on) begin
      sample_out.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      sample_out.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      sample_out.ready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      sample_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dac_code_t want;
    if (!rst && sample_out.valid && sample_out.ready) begin
      if (pending_codes.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample %0d pend %0b err %0b", $time,
                 sample_out.sample, sample_out.period_end, sample_out.index_error);
      end else begin
        want = pending_codes.pop_front();
        if (want.sample !== sample_out.sample ||
            want.period_end !== sample_out.period_end ||
            want.index_error !== sample_out.index_error) begin
          errors++;
          $display("%0t: expected sample %0d pend %0b err %0b, got %0d %0b %0b", $time,
                   want.sample, want.period_end, want.index_error,
                   sample_out.sample, sample_out.period_end, sample_out.index_error);
        end
      end
    end
  end

  task automatic send_index(input logic [IDX_W-1:0] idx);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      sample_in.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    sample_in.valid <= 1'b1;
    sample_in.sample_index <= idx;
    do @(posedge clk); while (!sample_in.ready);
    pending_codes.push_back(predict_code(idx));
  endtask

  task automatic drain();
    sample_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // leaves cfg_write high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      REG_WAVE_MODE: shape = wave_mode_t'(val[MODE_W-1:0]);
      REG_POINTS:    period_len = val[PPP_W-1:0];
      default:       ratio_q16 = val[RATIO_W-1:0];
    endcase
  endtask

  task automatic set_wave(input wave_mode_t m, input int unsigned n, input int unsigned r);
    drain();
    write_reg(REG_WAVE_MODE, m);
    write_reg(REG_POINTS, n);
    write_reg(REG_RATIO, r);
    cfg_write <= 1'b0;
  endtask

  task automatic test_reset_sine();
    send_index(0);
    send_index(64);
    send_index(128);
    send_index(192);
    send_index(255);
    send_index(256);
    send_index(4095);
  endtask

  task automatic test_square();
    set_wave(MODE_SQUARE, 4, 65536);
    for (int i = 0; i < 5; i++) send_index(i);
    set_wave(MODE_SQUARE, 7, 0);
    send_index(2);
    send_index(3);
  endtask

  task automatic test_triangle();
    set_wave(MODE_TRIANGLE, 5, 131071);
    for (int i = 0; i < 5; i++) send_index(i);
    set_wave(MODE_TRIANGLE, 4096, 32768);
    send_index(2047);
    send_index(2048);
    send_index(4095);
  endtask

  task automatic test_odd_periods();
    set_wave(MODE_SINE_ALT, 0, 1);
    send_index(0);
    set_wave(MODE_SINE, 8191, 65535);
    send_index(3072);
    send_index(4095);
  endtask

  task automatic test_random_phases(input int phases, input int per_phase);
    wave_mode_t   m;
    int unsigned  n, r;
    for (int p = 0; p < phases; p++) begin
      m = wave_mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0: n = $urandom_range(0, 8191);
        1: n = 4096;
        2: n = $urandom_range(4, 8);
        default: n = $urandom_range(4, 4096);
      endcase
      case ($urandom_range(0, 4))
        0: r = 0;
        1: r = 65536;
        2: r = $urandom_range(65537, 131071);
        default: r = $urandom_range(0, 65536);
      endcase
      set_wave(m, n, r);
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(0, 9) == 0 || n == 0) send_index($urandom_range(0, 4095));
        else send_index($urandom_range(0, (n > 4096 ? 4096 : n) - 1));
      end
      if (p == 2) drain(); // sender holds until every result is back
    end
  endtask

  initial begin
    errors = 0;
    gaps_on = 1'b0;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    sample_in.valid <= 1'b0;
    sample_in.sample_index <= '0;
    shape = MODE_SINE;
    period_len = 256;
    ratio_q16 = RATIO_ONE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gaps_on = 1'b1;
    test_reset_sine();
    test_square();
    test_triangle();
    test_odd_periods();
    test_random_phases(12, 100);
    gaps_on = 1'b0;
    test_random_phases(2, 50);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("dac_waveform_sample_generator: match");
    else $display("dac_waveform_sample_generator: mismatch");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/dwsg_pkg.sv
rtl/dwsg_if.sv
rtl/dwsg_front.sv
rtl/dwsg_div.sv
rtl/dwsg_back.sv
rtl/dac_waveform_sample_generator.sv
rtl/dwsg_checker.sv
tb/dac_waveform_sample_generator_test.sv
